@@ src/bitmap_set_with_find_first_assert.svh @@
// Assertion macros used by the bitmap controller
`ifndef BITMAP_SET_WITH_FIND_FIRST_ASSERT_SVH
`define BITMAP_SET_WITH_FIND_FIRST_ASSERT_SVH

`ifndef SYNTH

// Check a property on every rising clock edge outside of reset
`define BSFF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bitmap assertion failed");

// Check a property on every rising clock edge, reset included
`define BSFF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bitmap assertion failed");

`else

`define BSFF_ASSERT(lbl, clk, rst, prop)
`define BSFF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ src/bsff_pkg.sv @@
// Types, constants and helpers shared by the bitmap controller and datapath
`timescale 1ns / 1ps
`default_nettype none

package bsff_pkg;

   localparam int BITS      = 1024;
   localparam int WORD_BITS = 32;
   localparam int NWORDS    = (BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW   = $clog2(NWORDS);
   localparam int BIT_AW    = $clog2(WORD_BITS);
   localparam int OP_W      = 3;
   localparam int INDEX_W   = 10;
   localparam int SIZE_W    = 11;

   localparam logic [SIZE_W-1:0] SET_SIZE_RESET = SIZE_W'(BITS);

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [OP_W-1:0] {
      OP_SET       = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_TOGGLE    = 3'd2,
      OP_TEST      = 3'd3,
      OP_FIND      = 3'd4,
      OP_POP       = 3'd5,
      OP_CLEAR_ALL = 3'd6,
      OP_SET_ALL   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BIT,
      ST_SCAN,
      ST_FILL
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // capture request, read its first word
      logic advance;   // read next word
      logic wr_en;     // write back the current word
      logic load_rsp;  // capture the result word
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   index_err;
      logic   found;
      logic   last_word;
   } dp_stat_type;

   // Priority encode: position of the lowest set bit, zero when none
   function automatic logic [BIT_AW-1:0] lowest_set_bit(input word_type v);
      logic [BIT_AW-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = BIT_AW'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

@@ src/bitmap_set_with_find_first.sv @@
// Bitmap of 1024 bits: set, clear, toggle, test, find/pop first, clear/set all
// Use: the req channel carries one word per operation (operation, index,
// start_index); the rsp channel returns one word per operation (hit,
// result_index, error). The csr port holds set_size at byte address 0.
// Sequence: set, clear, toggle and test read their word on accept, then load
// the result into the output register. Find and pop scan one stored word per
// cycle through the single read port of the word store. Clear all and set all
// write one word per cycle. The block takes the next request word in the cycle
// after a result is captured.
// Reset: set_size returns to 1024 and the store reads as all zeros at once
// through per-word written flags; no clearing pass is needed.
// Stall: a result waits in the output register while the next word is
// accepted and worked on; that work holds at its final step until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_set_with_find_first (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // operation[2:0], index[12:3], start_index[22:13]
   // Result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // hit[0], result_index[10:1], error[11]
   // Register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bsff_pkg::*;

   localparam logic [2:0] ADDR_SET_SIZE = 3'd0;

   logic [SIZE_W-1:0]  set_size_ff;
   logic [SIZE_W-1:0]  set_size_in;
   op_type             req_op;
   logic [INDEX_W-1:0] req_index;
   logic [INDEX_W-1:0] req_start_index;
   logic               rsp_hit;
   logic [INDEX_W-1:0] rsp_result_index;
   logic               rsp_error;
   dp_cmd_type         cmd;
   dp_stat_type        stat;

   // Unpack request word
   assign req_op          = op_type'(req_tdata[OP_W-1:0]);
   assign req_index       = req_tdata[OP_W +: INDEX_W];
   assign req_start_index = req_tdata[OP_W + INDEX_W +: INDEX_W];

   // Register write
   always_comb begin
      set_size_in = set_size_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr == ADDR_SET_SIZE) begin
         set_size_in = csr_pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= SET_SIZE_RESET;
      end else begin
         set_size_ff <= set_size_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_SET_SIZE) ? 32'(set_size_ff) : 32'd0;

   bsff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_op),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bsff_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .set_size         (set_size_ff),
      .req_op           (req_op),
      .req_index        (req_index),
      .req_start_index  (req_start_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_hit          (rsp_hit),
      .rsp_result_index (rsp_result_index),
      .rsp_error        (rsp_error)
   );

   // Pack result word
   assign rsp_tdata = {4'b0000, rsp_error, rsp_result_index, rsp_hit};

endmodule

`default_nettype wire

@@ src/bsff_dp.sv @@
// Datapath: word store, word counter, masking, priority encoder, result register
`timescale 1ns / 1ps
`default_nettype none

module bsff_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [bsff_pkg::SIZE_W-1:0]   set_size,
   input  wire bsff_pkg::op_type              req_op,
   input  wire logic [bsff_pkg::INDEX_W-1:0]  req_index,
   input  wire logic [bsff_pkg::INDEX_W-1:0]  req_start_index,
   input  wire bsff_pkg::dp_cmd_type          cmd,
   output bsff_pkg::dp_stat_type              stat,
   output logic                               rsp_hit,
   output logic [bsff_pkg::INDEX_W-1:0]       rsp_result_index,
   output logic                               rsp_error
);
   import bsff_pkg::*;

   // Store and its per-word written flags
   word_type             mem_ff [NWORDS];
   logic [NWORDS-1:0]    written_ff;
   word_type             rd_data_ff;
   logic                 rd_written_ff;

   op_type               op_ff;
   logic [INDEX_W-1:0]   index_ff;
   logic [WORD_AW-1:0]   word_ff;
   logic [WORD_AW-1:0]   word_in;

   logic                 hit_ff;
   logic [INDEX_W-1:0]   result_index_ff;
   logic                 error_ff;

   logic [WORD_AW-1:0]   first_word;
   logic [WORD_AW-1:0]   rd_addr;
   logic                 rd_en;
   logic [SIZE_W-1:0]    size_use;
   logic [SIZE_W-1:0]    word_base;
   logic [SIZE_W-1:0]    remain;
   word_type             valid_mask;
   word_type             cur_word;
   word_type             masked;
   word_type             bit_mask;
   word_type             wr_word;
   logic [BIT_AW-1:0]    bit_pos;
   logic [BIT_AW-1:0]    low_pos;
   logic                 found;
   logic                 index_err;

   // First word a request reads
   always_comb begin
      case (req_op)
         OP_SET, OP_CLEAR, OP_TOGGLE, OP_TEST: first_word = req_index[BIT_AW +: WORD_AW];
         OP_POP:  first_word = req_start_index[BIT_AW +: WORD_AW];
         default: first_word = '0;
      endcase
   end

   assign rd_en   = cmd.accept | cmd.advance;
   assign rd_addr = cmd.accept ? first_word : word_ff + WORD_AW'(1);
   assign word_in = rd_en ? rd_addr : word_ff;

   // Clamp size, build mask of in-use bits for the current word
   assign size_use  = (set_size > SIZE_W'(BITS)) ? SIZE_W'(BITS) : set_size;
   assign word_base = SIZE_W'({word_ff, {BIT_AW{1'b0}}});
   assign remain    = size_use - word_base;

   always_comb begin
      if (word_base >= size_use) begin
         valid_mask = '0;
      end else if (remain >= SIZE_W'(WORD_BITS)) begin
         valid_mask = '1;
      end else begin
         valid_mask = (word_type'(1) << remain[BIT_AW-1:0]) - word_type'(1);
      end
   end

   // Unwritten words read as zero
   assign cur_word  = rd_written_ff ? rd_data_ff : '0;
   assign masked    = cur_word & valid_mask;
   assign found     = |masked;
   assign low_pos   = lowest_set_bit(masked);
   assign bit_pos   = index_ff[BIT_AW-1:0];
   assign bit_mask  = word_type'(1) << bit_pos;
   assign index_err = SIZE_W'(index_ff) >= size_use;

   // Write-back word per operation
   always_comb begin
      case (op_ff)
         OP_SET:     wr_word = cur_word | bit_mask;
         OP_CLEAR:   wr_word = cur_word & ~bit_mask;
         OP_TOGGLE:  wr_word = cur_word ^ bit_mask;
         OP_POP:     wr_word = cur_word & ~(word_type'(1) << low_pos);
         OP_SET_ALL: wr_word = valid_mask;
         default:    wr_word = '0;
      endcase
   end

   // Capture request fields
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_op;
         index_ff <= req_index;
      end
      word_ff <= word_in;
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[word_ff] <= wr_word;
      end
      if (rd_en) begin
         rd_data_ff    <= mem_ff[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   // Mark words as written, clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (cmd.wr_en) begin
         written_ff[word_ff] <= 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         case (op_ff)
            OP_SET, OP_CLEAR, OP_TOGGLE: begin
               hit_ff          <= 1'b0;
               result_index_ff <= '0;
               error_ff        <= index_err;
            end
            OP_TEST: begin
               hit_ff          <= ~index_err & cur_word[bit_pos];
               result_index_ff <= '0;
               error_ff        <= index_err;
            end
            OP_FIND, OP_POP: begin
               hit_ff          <= found;
               result_index_ff <= found ? INDEX_W'({word_ff, low_pos}) : '0;
               error_ff        <= 1'b0;
            end
            default: begin
               hit_ff          <= 1'b0;
               result_index_ff <= '0;
               error_ff        <= 1'b0;
            end
         endcase
      end
   end

   assign stat.op        = op_ff;
   assign stat.index_err = index_err;
   assign stat.found     = found;
   assign stat.last_word = (word_ff == WORD_AW'(NWORDS - 1));

   assign rsp_hit          = hit_ff;
   assign rsp_result_index = result_index_ff;
   assign rsp_error        = error_ff;

endmodule

`default_nettype wire

@@ src/bsff_ctrl.sv @@
// Controller: sequences bit updates, word scans and fills, owns the handshakes
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_set_with_find_first_assert.svh"

module bsff_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire bsff_pkg::op_type      req_op,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire bsff_pkg::dp_stat_type stat,
   output bsff_pkg::dp_cmd_type       cmd
);
   import bsff_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // Output slot can take a word this cycle
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (req_op) inside
                  OP_SET, OP_CLEAR, OP_TOGGLE, OP_TEST: state_in = ST_BIT;
                  OP_FIND, OP_POP:                      state_in = ST_SCAN;
                  default:                              state_in = ST_FILL;
               endcase
            end
         end
         ST_BIT: begin
            if (out_free) begin
               cmd.wr_en    = ~stat.index_err & (stat.op != OP_TEST);
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (stat.found | stat.last_word) begin
               // Finish once the output slot is free
               if (out_free) begin
                  cmd.wr_en    = stat.found & (stat.op == OP_POP);
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_FILL: begin
            cmd.wr_en = 1'b1;
            if (stat.last_word) begin
               if (out_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result word until taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `BSFF_ASSERT(a_no_overwrite, clock, reset, cmd.load_rsp |-> out_free)
   `BSFF_ASSERT(a_accept_leaves_idle, clock, reset, (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
   `BSFF_ASSERT(a_scan_ends_at_last, clock, reset, (state_ff == ST_SCAN && stat.last_word && out_free) |-> cmd.load_rsp)
   `BSFF_ASSERT(a_write_only_busy, clock, reset, cmd.wr_en |-> (state_ff != ST_IDLE))

endmodule

`default_nettype wire
